/* design/ptst_pkg.sv */
// Package: shared types, codes and sizing constants of the periodic timer slot table.
package ptst_pkg;

	localparam int SLOTS       = 16;
	localparam int MAX_RESULTS = 16;
	localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int TIME_W      = 32;

	typedef enum logic [1:0] {
		REQ_ADD     = 2'd0,
		REQ_REMOVE  = 2'd1,
		REQ_TICK    = 2'd2,
		REQ_SETCOND = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		MODE_NEVER   = 2'd0,
		MODE_COUNT   = 2'd1,
		MODE_ELAPSED = 2'd2,
		MODE_COND    = 2'd3
	} mode_e_t;

	typedef enum logic [2:0] {
		KIND_ADDED    = 3'd0,
		KIND_FULL     = 3'd1,
		KIND_REMOVED  = 3'd2,
		KIND_FIRED    = 3'd3,
		KIND_NONE_DUE = 3'd4,
		KIND_COND_SET = 3'd5
	} kind_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FLUSH
	} state_e_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic exec;
		logic step;
		logic flush;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_is_tick;
		logic out_free;
		logic fire;
		logic pend_valid;
		logic scan_last;
	} sts_t;

endpackage

/* design/ptst_req_if.sv */
// Interface: request channel of the timer slot table.
interface ptst_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] now_ms;
	logic [31:0] period_ms;
	logic [1:0]  expiry_mode;
	logic [31:0] expiry_target;
	logic [3:0]  slot_index;

	modport source (output valid, req_type, now_ms, period_ms, expiry_mode, expiry_target,
		slot_index, input ready);
	modport sink (input valid, req_type, now_ms, period_ms, expiry_mode, expiry_target,
		slot_index, output ready);
endinterface

/* design/ptst_res_if.sv */
// Interface: result channel of the timer slot table.
interface ptst_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [3:0] slot_id;
	logic       expired;
	logic       last;

	modport source (output valid, kind, slot_id, expired, last, input ready);
	modport sink (input valid, kind, slot_id, expired, last, output ready);
endinterface

/* design/ptst_ctrl.sv */
// Controller: state machine sequencing request decode, slot scan and result flush.
module ptst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ptst_pkg::sts_t sts,
	output ptst_pkg::cmd_t cmd
);

	ptst_pkg::state_e_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ptst_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = sts.in_is_tick ? ptst_pkg::ST_SCAN : ptst_pkg::ST_EXEC;
				end
			end
			ptst_pkg::ST_EXEC: begin
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = ptst_pkg::ST_IDLE;
				end
			end
			ptst_pkg::ST_SCAN: begin
				// hold the scan when a firing must push out the pending item
				if (!(sts.fire && sts.pend_valid && !sts.out_free)) begin
					cmd.step = 1'b1;
					if (sts.scan_last) begin
						state_d = ptst_pkg::ST_FLUSH;
					end
				end
			end
			ptst_pkg::ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ptst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptst_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* design/ptst_dp.sv */
// Datapath: slot table storage, expiry arithmetic, pending result and output register.
module ptst_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  ptst_pkg::cmd_t cmd,
	output ptst_pkg::sts_t sts,
	input  logic [1:0]     in_req_type,
	input  logic [31:0]    in_now_ms,
	input  logic [31:0]    in_period_ms,
	input  logic [1:0]     in_expiry_mode,
	input  logic [31:0]    in_expiry_target,
	input  logic [3:0]     in_slot_index,
	input  logic           out_ready,
	output logic           out_valid,
	output logic [2:0]     out_kind,
	output logic [3:0]     out_slot_id,
	output logic           out_expired,
	output logic           out_last
);

	localparam int SW = ptst_pkg::SLOT_W;
	localparam int CW = ptst_pkg::CNT_W;
	localparam int TW = ptst_pkg::TIME_W;

	// latched request
	logic [1:0]    req_q;
	logic [TW-1:0] now_q;
	logic [TW-1:0] period_q;
	logic [1:0]    mode_q;
	logic [TW-1:0] target_q;
	logic [3:0]    index_q;

	// slot table
	logic [ptst_pkg::SLOTS-1:0] active_q;
	logic [TW-1:0]              due_q      [ptst_pkg::SLOTS];
	logic [TW-1:0]              per_q      [ptst_pkg::SLOTS];
	logic [1:0]                 smode_q    [ptst_pkg::SLOTS];
	logic [TW-1:0]              prog_q     [ptst_pkg::SLOTS];
	logic [TW-1:0]              tgt_q      [ptst_pkg::SLOTS];

	// scan and pending result
	logic [SW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic          pend_valid_q;
	logic [SW-1:0] pend_slot_q;
	logic          pend_exp_q;

	// output register
	logic          out_valid_q;
	logic [2:0]    out_kind_q;
	logic [3:0]    out_slot_q;
	logic          out_exp_q;
	logic          out_last_q;

	logic          out_free;
	logic          found;
	logic [SW-1:0] free_idx;
	logic          in_range;
	logic [SW-1:0] tgt_idx;
	logic          cond_ok;

	logic [TW-1:0] cur_due, cur_per, cur_prog, cur_tgt;
	logic [1:0]    cur_mode;
	logic          fire;
	logic [TW-1:0] due_sum;
	logic [TW-1:0] addend;
	logic [TW:0]   prog_sum;
	logic          ge;
	logic          gone;
	logic [TW-1:0] prog_next;

	logic                 ld;
	ptst_pkg::kind_e_t    ld_kind;
	logic [3:0]           ld_slot;
	logic                 ld_exp;
	logic                 ld_last;

	assign out_free = !out_valid_q || out_ready;

	// lowest free slot
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int i = ptst_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				found    = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign in_range = 32'(index_q) < 32'(ptst_pkg::SLOTS);
	assign tgt_idx  = SW'(index_q);
	assign cond_ok  = in_range && active_q[tgt_idx] && (smode_q[tgt_idx] == ptst_pkg::MODE_COND);

	// current scan entry and its expiry rule
	assign cur_due  = due_q[idx_q];
	assign cur_per  = per_q[idx_q];
	assign cur_prog = prog_q[idx_q];
	assign cur_tgt  = tgt_q[idx_q];
	assign cur_mode = smode_q[idx_q];

	assign fire     = active_q[idx_q] && (cur_due <= now_q) && (n_q < CW'(ptst_pkg::MAX_RESULTS));
	assign due_sum  = cur_due + cur_per;
	assign addend   = (cur_mode == ptst_pkg::MODE_COUNT) ? TW'(1) : cur_per;
	assign prog_sum = {1'b0, cur_prog} + {1'b0, addend};
	assign ge       = cur_prog >= cur_tgt;

	always_comb begin
		gone      = 1'b0;
		prog_next = cur_prog;
		case (cur_mode)
			ptst_pkg::MODE_COUNT: begin
				gone      = ge;
				prog_next = ge ? '0 : prog_sum[TW-1:0];
			end
			ptst_pkg::MODE_ELAPSED: begin
				gone      = ge;
				prog_next = ge ? '0 : (prog_sum[TW] ? '1 : prog_sum[TW-1:0]);
			end
			ptst_pkg::MODE_COND: begin
				gone      = cur_prog != '0;
				prog_next = gone ? '0 : cur_prog;
			end
			default: begin
				gone      = 1'b0;
				prog_next = cur_prog;
			end
		endcase
	end

	// result selection for the output register
	always_comb begin
		ld      = 1'b0;
		ld_kind = ptst_pkg::KIND_NONE_DUE;
		ld_slot = '0;
		ld_exp  = 1'b0;
		ld_last = 1'b1;
		if (cmd.exec) begin
			ld = 1'b1;
			case (req_q)
				ptst_pkg::REQ_ADD: begin
					ld_kind = found ? ptst_pkg::KIND_ADDED : ptst_pkg::KIND_FULL;
					ld_slot = found ? 4'(free_idx) : 4'd0;
				end
				ptst_pkg::REQ_REMOVE: begin
					ld_kind = ptst_pkg::KIND_REMOVED;
					ld_slot = index_q;
				end
				ptst_pkg::REQ_SETCOND: begin
					ld_kind = ptst_pkg::KIND_COND_SET;
					ld_slot = index_q;
				end
				default: begin
					ld_kind = ptst_pkg::KIND_NONE_DUE;
				end
			endcase
		end else if (cmd.step && fire && pend_valid_q) begin
			ld      = 1'b1;
			ld_kind = ptst_pkg::KIND_FIRED;
			ld_slot = 4'(pend_slot_q);
			ld_exp  = pend_exp_q;
			ld_last = 1'b0;
		end else if (cmd.flush) begin
			ld = 1'b1;
			if (pend_valid_q) begin
				ld_kind = ptst_pkg::KIND_FIRED;
				ld_slot = 4'(pend_slot_q);
				ld_exp  = pend_exp_q;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= '0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			idx_q        <= '0;
			n_q          <= '0;
		end else begin
			if (cmd.latch) begin
				idx_q        <= '0;
				n_q          <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.exec) begin
				case (req_q)
					ptst_pkg::REQ_ADD: begin
						if (found) begin
							active_q[free_idx] <= 1'b1;
						end
					end
					ptst_pkg::REQ_REMOVE: begin
						if (in_range) begin
							active_q[tgt_idx] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.step) begin
				idx_q <= idx_q + SW'(1);
				if (fire) begin
					n_q          <= n_q + CW'(1);
					pend_valid_q <= 1'b1;
					if (gone) begin
						active_q[idx_q] <= 1'b0;
					end
				end
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q    <= in_req_type;
			now_q    <= in_now_ms;
			period_q <= in_period_ms;
			mode_q   <= in_expiry_mode;
			target_q <= in_expiry_target;
			index_q  <= in_slot_index;
		end
		if (cmd.exec) begin
			case (req_q)
				ptst_pkg::REQ_ADD: begin
					if (found) begin
						due_q[free_idx]   <= now_q;
						per_q[free_idx]   <= period_q;
						smode_q[free_idx] <= mode_q;
						prog_q[free_idx]  <= '0;
						tgt_q[free_idx]   <= target_q;
					end
				end
				ptst_pkg::REQ_REMOVE: begin
					if (in_range) begin
						smode_q[tgt_idx] <= ptst_pkg::MODE_NEVER;
						prog_q[tgt_idx]  <= '0;
					end
				end
				ptst_pkg::REQ_SETCOND: begin
					if (cond_ok) begin
						prog_q[tgt_idx] <= TW'(1);
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.step && fire) begin
			due_q[idx_q]  <= due_sum;
			prog_q[idx_q] <= prog_next;
			pend_slot_q   <= idx_q;
			pend_exp_q    <= gone;
			if (gone) begin
				smode_q[idx_q] <= ptst_pkg::MODE_NEVER;
			end
		end
		if (ld) begin
			out_kind_q <= ld_kind;
			out_slot_q <= ld_slot;
			out_exp_q  <= ld_exp;
			out_last_q <= ld_last;
		end
	end

	assign sts.in_is_tick = in_req_type == ptst_pkg::REQ_TICK;
	assign sts.out_free   = out_free;
	assign sts.fire       = fire;
	assign sts.pend_valid = pend_valid_q;
	assign sts.scan_last  = idx_q == SW'(ptst_pkg::SLOTS - 1);

	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign out_slot_id = out_slot_q;
	assign out_expired = out_exp_q;
	assign out_last    = out_last_q;

endmodule

/* design/periodic_timer_slot_table.sv */
// Top level: periodic timer slot table, controller plus datapath.
//
// Requests enter on the req channel (valid/ready), results leave on the res
// channel (valid/ready); every request yields one or more result items, the
// final one flagged by last.
// Add, remove and set-condition pass through the decode state (EXEC), which
// loads the result into the output register once that is free; a new request
// is accepted only after the block has returned to idle.
// A tick walks the slot table one slot per cycle in ascending order, unless a
// firing must push out the pending item while the output register is full;
// a flush state then emits the final result. The single scan port sets this rate.
// Each firing is held in a pending register until the next firing or the
// end of the scan decides whether it is the last item of the tick.
// The output register frees the request side: a new request is accepted
// while a finished result still waits. When the receiver stalls, the
// block holds its state and the scan pauses wherever it must emit.
// Reset (arst_n low) marks every slot free and drops any result in flight;
// the block accepts a request as soon as reset is released.
module periodic_timer_slot_table (
	input  logic            clk,
	input  logic            arst_n,
	ptst_req_if.sink        req,
	ptst_res_if.source      res
);

	ptst_pkg::cmd_t cmd;
	ptst_pkg::sts_t sts;

	// sequence decode, scan and flush
	ptst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table storage, expiry rules and output register
	ptst_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_req_type      (req.req_type),
		.in_now_ms        (req.now_ms),
		.in_period_ms     (req.period_ms),
		.in_expiry_mode   (req.expiry_mode),
		.in_expiry_target (req.expiry_target),
		.in_slot_index    (req.slot_index),
		.out_ready        (res.ready),
		.out_valid        (res.valid),
		.out_kind         (res.kind),
		.out_slot_id      (res.slot_id),
		.out_expired      (res.expired),
		.out_last         (res.last)
	);

endmodule

/* design/ptst_checker.sv */
// Checker: port-level assertions for the timer slot table, bound to the top level.
module ptst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] res_kind,
	input logic [3:0] res_slot_id,
	input logic       res_expired,
	input logic       res_last
);

	// hold a stalled result unchanged
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_slot_id)
			&& $stable(res_expired) && $stable(res_last))
		else $error("stalled result changed");

	// one request in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in work");

	// only firings may continue a request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != ptst_pkg::KIND_FIRED |-> res_last)
		else $error("non-firing result without last");

	// expiry flag only on firings
	a_expired_fired: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_expired |-> res_kind == ptst_pkg::KIND_FIRED)
		else $error("expired set on a non-firing result");

endmodule

bind periodic_timer_slot_table ptst_checker u_ptst_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_kind    (res.kind),
	.res_slot_id (res.slot_id),
	.res_expired (res.expired),
	.res_last    (res.last)
);
